// File: hw/rtl/button_press_classifier_macros.svh
// ---------------------------------------------------------------------------
// Button press classifier assertion macros
// Shared property wrappers clocked on clk_i and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/bpc_pkg.sv
// ---------------------------------------------------------------------------
// Button press classifier package
// Types, register map and reset values shared by the classifier modules.
// ---------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int unsigned ThrW  = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [ThrW-1:0] DebounceRst = 16'd50;
  localparam logic [ThrW-1:0] ShortRst    = 16'd50;
  localparam logic [ThrW-1:0] LongRst     = 16'd1000;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_HELD     = 2'd2,
    PH_RELEASED = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_SHORT    = 2'd1,
    REG_LONG     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [ThrW-1:0] debounce_ms;
    logic [ThrW-1:0] short_press_ms;
    logic [ThrW-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    phase_e           phase;
    logic [TimeW-1:0] change_time;
    logic             short_event;
    logic             long_event;
  } state_t;

  typedef struct packed {
    logic   event_valid;
    logic   long_press;
    phase_e phase;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/bpc_step.sv
// ---------------------------------------------------------------------------
// Button press classifier step logic
// Next state and result for one request, from the current state and config.
// ---------------------------------------------------------------------------
`default_nettype none

module bpc_step (
  input  bpc_pkg::cfg_t                   cfg_i,
  input  bpc_pkg::state_t                 state_i,
  input  logic                            req_type_i,
  input  logic                            pressed_i,
  input  logic [bpc_pkg::TimeW-1:0]       now_ms_i,
  output bpc_pkg::state_t                 state_o,
  output bpc_pkg::result_t                result_o
);

  logic [bpc_pkg::TimeW-1:0] elapsed;
  logic                      short_met;
  logic                      long_met;
  logic                      debounce_met;

  // Time since the last edge, wrapping modulo 2^32.
  assign elapsed      = now_ms_i - state_i.change_time;
  assign short_met    = elapsed >= {{(bpc_pkg::TimeW-bpc_pkg::ThrW){1'b0}},
                                    cfg_i.short_press_ms};
  assign long_met     = elapsed >= {{(bpc_pkg::TimeW-bpc_pkg::ThrW){1'b0}},
                                    cfg_i.long_press_ms};
  assign debounce_met = elapsed >= {{(bpc_pkg::TimeW-bpc_pkg::ThrW){1'b0}},
                                    cfg_i.debounce_ms};

  always_comb begin
    state_o              = state_i;
    result_o.event_valid = 1'b0;
    result_o.long_press  = 1'b0;
    if (req_type_i) begin
      // The long event is reported ahead of a pending short one.
      if (state_i.long_event) begin
        state_o.long_event   = 1'b0;
        result_o.event_valid = 1'b1;
        result_o.long_press  = 1'b1;
      end else if (state_i.short_event) begin
        state_o.short_event  = 1'b0;
        result_o.event_valid = 1'b1;
      end
    end else begin
      case (state_i.phase)
        bpc_pkg::PH_IDLE: begin
          if (pressed_i) begin
            state_o.phase       = bpc_pkg::PH_PRESSED;
            state_o.change_time = now_ms_i;
          end
        end
        bpc_pkg::PH_PRESSED: begin
          if (!pressed_i) begin
            if (short_met) begin
              state_o.short_event = 1'b1;
            end
            state_o.phase       = bpc_pkg::PH_RELEASED;
            state_o.change_time = now_ms_i;
          end else if (long_met) begin
            state_o.phase      = bpc_pkg::PH_HELD;
            state_o.long_event = 1'b1;
          end
        end
        bpc_pkg::PH_HELD: begin
          if (!pressed_i) begin
            state_o.phase       = bpc_pkg::PH_RELEASED;
            state_o.change_time = now_ms_i;
          end
        end
        bpc_pkg::PH_RELEASED: begin
          if (pressed_i) begin
            state_o.phase       = bpc_pkg::PH_PRESSED;
            state_o.change_time = now_ms_i;
          end else if (debounce_met) begin
            state_o.phase = bpc_pkg::PH_IDLE;
          end
        end
        default: begin
          state_o.phase = bpc_pkg::PH_IDLE;
        end
      endcase
    end
    result_o.phase = state_o.phase;
  end

endmodule

`default_nettype wire

// File: hw/rtl/button_press_classifier.sv
// ---------------------------------------------------------------------------
// Button press classifier
// Short and long press detector for one push button, with an APB config port.
// ---------------------------------------------------------------------------
// Requests arrive on a valid/ready channel: req_type_i = 0 is a level sample
// (pressed_i, now_ms_i), req_type_i = 1 queries and clears a latched press
// event. Every request yields exactly one result on the output valid/ready
// channel: event_valid_o, long_press_o and the state after the request.
// The state update and result are computed in the cycle a request is
// accepted and appear in the output register on the next cycle, and one
// request is taken every cycle while results drain.
// The single output register governs this: when it holds a result the
// receiver has not taken, in_ready_o follows out_ready_i, and a stalled
// receiver holds the result and stops further requests.
// Reset puts the machine in idle with no events latched and the thresholds
// at 50 ms debounce, 50 ms short press and 1000 ms long press. Thresholds go
// through the APB port at byte addresses 0, 4 and 8; the user must write them
// only while the block is idle, not enforced by it; pready is always high.
// ---------------------------------------------------------------------------
`default_nettype none
`include "button_press_classifier_macros.svh"

module button_press_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic                          pressed_i,
  input  logic [bpc_pkg::TimeW-1:0]     now_ms_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          event_valid_o,
  output logic                          long_press_o,
  output logic [1:0]                    fsm_state_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpc_pkg::AddrW-1:0]     paddr,
  input  logic [bpc_pkg::DataW-1:0]     pwdata,
  output logic [bpc_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  bpc_pkg::cfg_t     cfg_q;
  bpc_pkg::state_t   state_q;
  bpc_pkg::state_t   state_d;
  bpc_pkg::result_t  result_d;
  bpc_pkg::result_t  result_q;
  logic              out_valid_q;
  logic              in_fire;
  logic              cfg_write;
  bpc_pkg::reg_idx_e reg_idx;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = bpc_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms    <= bpc_pkg::DebounceRst;
      cfg_q.short_press_ms <= bpc_pkg::ShortRst;
      cfg_q.long_press_ms  <= bpc_pkg::LongRst;
    end else if (cfg_write) begin
      case (reg_idx)
        bpc_pkg::REG_DEBOUNCE: cfg_q.debounce_ms    <= pwdata[bpc_pkg::ThrW-1:0];
        bpc_pkg::REG_SHORT:    cfg_q.short_press_ms <= pwdata[bpc_pkg::ThrW-1:0];
        bpc_pkg::REG_LONG:     cfg_q.long_press_ms  <= pwdata[bpc_pkg::ThrW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bpc_pkg::REG_DEBOUNCE: begin
        prdata = {{(bpc_pkg::DataW-bpc_pkg::ThrW){1'b0}}, cfg_q.debounce_ms};
      end
      bpc_pkg::REG_SHORT: begin
        prdata = {{(bpc_pkg::DataW-bpc_pkg::ThrW){1'b0}}, cfg_q.short_press_ms};
      end
      bpc_pkg::REG_LONG: begin
        prdata = {{(bpc_pkg::DataW-bpc_pkg::ThrW){1'b0}}, cfg_q.long_press_ms};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  bpc_step u_step (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .req_type_i (req_type_i),
    .pressed_i  (pressed_i),
    .now_ms_i   (now_ms_i),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= bpc_pkg::PH_IDLE;
      state_q.change_time <= '0;
      state_q.short_event <= 1'b0;
      state_q.long_event  <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_valid_o = result_q.event_valid;
  assign long_press_o  = result_q.long_press;
  assign fsm_state_o   = result_q.phase;

  // A sample never reports an event.
  `BPC_ASSERT_NEXT(a_sample_no_event, in_fire && !req_type_i,
                   out_valid_o && !event_valid_o, "sample request reported an event")
  // A query with a latched long event reports it as long.
  `BPC_ASSERT_NEXT(a_query_long_first, in_fire && req_type_i && state_q.long_event,
                   event_valid_o && long_press_o && !state_q.long_event,
                   "latched long event not reported first")
  // A query leaves the phase and the edge time alone.
  `BPC_ASSERT_NEXT(a_query_keeps_phase, in_fire && req_type_i,
                   state_q.phase == $past(state_q.phase) &&
                   state_q.change_time == $past(state_q.change_time),
                   "query changed the button phase")
  // The reported state always matches the stored phase right after a request.
  `BPC_ASSERT_NEXT(a_state_matches, in_fire,
                   fsm_state_o == state_q.phase, "reported state differs from phase")

endmodule

`default_nettype wire

// File: verif/bpc_tb_pkg.sv
// ---------------------------------------------------------------------------
// Button press classifier verification package
// Request kinds shared by the stimulus and the checker.
// ---------------------------------------------------------------------------
package bpc_tb_pkg;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_QUERY  = 1'b1
  } req_kind_e;

  localparam int unsigned MaxGap = 16;

endpackage

// File: verif/bpc_checker.sv
// ---------------------------------------------------------------------------
// Button press classifier checker
// Follows the request, result and APB channels, keeps its own copy of the
// press state machine and compares every result with the predicted one.
// ---------------------------------------------------------------------------
module bpc_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  logic                      req_ready_i,
  input  logic                      req_type_i,
  input  logic                      pressed_i,
  input  logic [bpc_pkg::TimeW-1:0] now_ms_i,
  input  logic                      res_valid_i,
  input  logic                      res_ready_i,
  input  logic                      event_valid_i,
  input  logic                      long_press_i,
  input  logic [1:0]                fsm_state_i,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [bpc_pkg::AddrW-1:0] paddr_i,
  input  logic [bpc_pkg::DataW-1:0] pwdata_i,
  input  logic                      pready_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;
  import bpc_tb_pkg::*;

  cfg_t             thresholds;
  phase_e           btn_phase;
  logic [TimeW-1:0] last_change;
  logic             short_latched;
  logic             long_latched;
  result_t          due_reports[$];
  int unsigned      mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $realtime, what);
  endtask

  // Advances the state machine by one request and returns its result.
  function automatic result_t classify_request(input logic kind, input logic down,
                                               input logic [TimeW-1:0] stamp);
    result_t          res;
    logic [TimeW-1:0] elapsed;
    res     = '0;
    elapsed = stamp - last_change;
    if (kind == REQ_QUERY) begin
      if (long_latched) begin
        long_latched    = 1'b0;
        res.event_valid = 1'b1;
        res.long_press  = 1'b1;
      end else if (short_latched) begin
        short_latched   = 1'b0;
        res.event_valid = 1'b1;
      end
    end else begin
      case (btn_phase)
        PH_IDLE: begin
          if (down) begin
            btn_phase   = PH_PRESSED;
            last_change = stamp;
          end
        end
        PH_PRESSED: begin
          if (!down) begin
            if (elapsed >= TimeW'(thresholds.short_press_ms)) short_latched = 1'b1;
            btn_phase   = PH_RELEASED;
            last_change = stamp;
          end else if (elapsed >= TimeW'(thresholds.long_press_ms)) begin
            btn_phase    = PH_HELD;
            long_latched = 1'b1;
          end
        end
        PH_HELD: begin
          if (!down) begin
            btn_phase   = PH_RELEASED;
            last_change = stamp;
          end
        end
        default: begin
          if (down) begin
            btn_phase   = PH_PRESSED;
            last_change = stamp;
          end else if (elapsed >= TimeW'(thresholds.debounce_ms)) begin
            btn_phase = PH_IDLE;
          end
        end
      endcase
    end
    res.phase = btn_phase;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      thresholds    = '{debounce_ms: DebounceRst, short_press_ms: ShortRst,
                        long_press_ms: LongRst};
      btn_phase     = PH_IDLE;
      last_change   = '0;
      short_latched = 1'b0;
      long_latched  = 1'b0;
      due_reports.delete();
    end else begin
      // Results leave the output register only after their request was accepted,
      // so the comparison always concerns a request from an earlier edge.
      if (res_valid_i && res_ready_i) begin
        if (due_reports.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: ev=%0b long=%0b st=%0d",
                                    event_valid_i, long_press_i, fsm_state_i));
        end else begin
          want = due_reports.pop_front();
          if (event_valid_i !== want.event_valid) begin
            report_mismatch($sformatf("event_valid %0b, predicted %0b",
                                      event_valid_i, want.event_valid));
          end
          if (long_press_i !== want.long_press) begin
            report_mismatch($sformatf("long_press %0b, predicted %0b",
                                      long_press_i, want.long_press));
          end
          if (fsm_state_i !== want.phase) begin
            report_mismatch($sformatf("fsm_state %0d, predicted %s",
                                      fsm_state_i, want.phase.name()));
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[AddrW-1:2])
          REG_DEBOUNCE: thresholds.debounce_ms    = pwdata_i[ThrW-1:0];
          REG_SHORT:    thresholds.short_press_ms = pwdata_i[ThrW-1:0];
          REG_LONG:     thresholds.long_press_ms  = pwdata_i[ThrW-1:0];
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i) begin
        due_reports.push_back(classify_request(req_type_i, pressed_i, now_ms_i));
      end
    end
    pending_o    <= due_reports.size();
    fail_count_o <= mismatches;
  end

endmodule

// File: verif/testbench.sv
// ---------------------------------------------------------------------------
// Button press classifier testbench
// Directed press sequences, then random press cycles under six threshold
// settings with random gaps on both channels; the checker judges results.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;
  import bpc_tb_pkg::*;

  localparam int unsigned      IdleLimit       = 2000;
  localparam int unsigned      ItemsPerSetting = 220;
  localparam logic [AddrW-1:0] UnmappedAddr    = AddrW'(4 * 3);

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic             req_type  = REQ_SAMPLE;
  logic             pressed   = 1'b0;
  logic [TimeW-1:0] now_ms    = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             event_valid;
  logic             long_press;
  logic [1:0]       fsm_state;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [AddrW-1:0] paddr     = '0;
  logic [DataW-1:0] pwdata    = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      idle_cycles = 0;
  int unsigned      sent_count  = 0;
  logic             calm        = 1'b0;
  logic [TimeW-1:0] mark        = 32'hFFFF_F000;
  cfg_t             cur_cfg     = '{debounce_ms: DebounceRst, short_press_ms: ShortRst,
                                    long_press_ms: LongRst};

  always #5 clk = ~clk;

  button_press_classifier i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (req_type),
    .pressed_i     (pressed),
    .now_ms_i      (now_ms),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .event_valid_o (event_valid),
    .long_press_o  (long_press),
    .fsm_state_o   (fsm_state),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  bpc_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (in_valid),
    .req_ready_i   (in_ready),
    .req_type_i    (req_type),
    .pressed_i     (pressed),
    .now_ms_i      (now_ms),
    .res_valid_i   (out_valid),
    .res_ready_i   (out_ready),
    .event_valid_i (event_valid),
    .long_press_i  (long_press),
    .fsm_state_i   (fsm_state),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  function automatic int unsigned draw_gap();
    if (calm) return 0;
    return $urandom_range(0, MaxGap);
  endfunction

  // Picks a time, mostly relative to base and sometimes around one of the thresholds.
  function automatic logic [TimeW-1:0] pick_time(input logic [TimeW-1:0] base);
    logic [TimeW-1:0] thr;
    case ($urandom_range(0, 2))
      0:       thr = TimeW'(cur_cfg.debounce_ms);
      1:       thr = TimeW'(cur_cfg.short_press_ms);
      default: thr = TimeW'(cur_cfg.long_press_ms);
    endcase
    case ($urandom_range(0, 5))
      0:       return base + TimeW'($urandom_range(0, 20));
      1, 2:    return base + thr + TimeW'($urandom_range(0, 2)) - 1;
      3:       return base + TimeW'($urandom_range(0, 3000));
      4:       return $urandom;
      default: return base;
    endcase
  endfunction

  // Called just after clk rises; returns as soon as the dut has accepted the request.
  task automatic send_request(input req_kind_e kind, input logic down,
                              input logic [TimeW-1:0] stamp);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    pressed  <= down;
    now_ms   <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_query();
    send_request(REQ_QUERY, 1'($urandom_range(0, 1)), $urandom);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic set_threshold(input reg_idx_e idx, input logic [ThrW-1:0] value);
    apb_write(AddrW'({idx, 2'b00}), {ThrW'($urandom), value});
    case (idx)
      REG_DEBOUNCE: cur_cfg.debounce_ms    = value;
      REG_SHORT:    cur_cfg.short_press_ms = value;
      default:      cur_cfg.long_press_ms  = value;
    endcase
  endtask

  task automatic set_config(input logic [ThrW-1:0] deb, input logic [ThrW-1:0] sh,
                            input logic [ThrW-1:0] lg);
    wait_idle();
    // A write outside the register map must leave every threshold alone.
    apb_write(UnmappedAddr, $urandom);
    set_threshold(REG_DEBOUNCE, deb);
    set_threshold(REG_SHORT, sh);
    set_threshold(REG_LONG, lg);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly complete press cycles (press, hold, release, settle) with
  // queries mixed in; the rest are arbitrary requests.
  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 19) == 0) calm = ~calm;
      if ($urandom_range(0, 7) == 0) begin
        send_request(req_kind_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
      end else begin
        mark = pick_time(mark);
        send_request(REQ_SAMPLE, 1'b1, mark);
        repeat ($urandom_range(0, 3)) begin
          send_request(REQ_SAMPLE, 1'b1, pick_time(mark));
          if ($urandom_range(0, 3) == 0) send_query();
        end
        mark = pick_time(mark);
        send_request(REQ_SAMPLE, 1'b0, mark);
        repeat ($urandom_range(0, 3)) begin
          send_request(REQ_SAMPLE, 1'b0, pick_time(mark));
          if ($urandom_range(0, 3) == 0) send_query();
        end
        repeat ($urandom_range(0, 2)) send_query();
      end
    end
  endtask

  // Result side: a random stall before each result is taken.
  initial begin
    int unsigned stall;
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: 50 ms debounce, 50 ms short, 1000 ms long.
    send_query();
    send_request(REQ_SAMPLE, 1'b0, 32'd0);
    send_request(REQ_SAMPLE, 1'b1, 32'd100);
    send_request(REQ_SAMPLE, 1'b1, 32'd149);
    send_request(REQ_SAMPLE, 1'b0, 32'd149);
    send_query();
    send_request(REQ_SAMPLE, 1'b1, 32'd160);
    send_request(REQ_SAMPLE, 1'b0, 32'd210);
    send_request(REQ_SAMPLE, 1'b0, 32'd259);
    send_request(REQ_SAMPLE, 1'b0, 32'd260);
    send_request(REQ_SAMPLE, 1'b1, 32'd300);
    send_request(REQ_SAMPLE, 1'b1, 32'd1299);
    send_request(REQ_SAMPLE, 1'b1, 32'd1300);
    send_request(REQ_SAMPLE, 1'b1, 32'hFFFF_FFFF);
    // Both events are latched now: long comes out first, then short.
    send_query();
    send_query();
    send_query();
    send_request(REQ_SAMPLE, 1'b0, 32'd6000);
    send_request(REQ_SAMPLE, 1'b1, 32'hFFFF_FFF0);
    send_request(REQ_SAMPLE, 1'b0, 32'h0000_0030);
    send_query();
    send_request(REQ_SAMPLE, 1'b0, 32'h0000_0062);

    set_config('0, '0, '0);
    run_random(ItemsPerSetting);
    set_config('1, '1, '1);
    run_random(ItemsPerSetting);
    set_config(ThrW'($urandom_range(0, 40)), ThrW'($urandom_range(0, 40)),
               ThrW'($urandom_range(0, 40)));
    run_random(ItemsPerSetting);
    set_config(ThrW'($urandom), ThrW'($urandom), ThrW'($urandom));
    run_random(ItemsPerSetting);
    set_config(ThrW'($urandom_range(0, 100)), ThrW'($urandom_range(1000, 1500)),
               ThrW'($urandom_range(0, 100)));
    run_random(ItemsPerSetting);
    set_config(DebounceRst, ShortRst, LongRst);
    run_random(ItemsPerSetting);

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
